// ===== rtl/core/mavg_pkg.sv =====
// Shared constants for the moving average / min-max unit.
// Sequencer state codes used by the front and back parts, and a byte padding helper.
// No dependencies.
`default_nettype none

package mavg_pkg;

    localparam int STATE_W = 2;

    localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] ST_RUN  = 2'd1;
    localparam logic [STATE_W-1:0] ST_OUT  = 2'd2;

    // round a bit count up to a whole number of bytes (result in bits)
    function automatic int pad_bytes(input int bits);
        return (bits + 7) & ~32'sd7;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mavg_front.sv =====
// Front part: accepts samples, keeps the sample ring, window sum, fill count and min/max.
// Emits one job per item (sum, count, enable, min, max) toward the divider queue.
// Depends on mavg_pkg.
`default_nettype none

module mavg_front #(
    parameter int WINDOW = 100,
    parameter int SAMPLE_BITS = 32,
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW),
    localparam int CNT_W = $clog2(WINDOW + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_avg_en,
    output logic                        o_job_valid,
    input  wire logic                   i_job_ready,
    output logic [SUM_W-1:0]            o_job_sum,
    output logic [CNT_W-1:0]            o_job_cnt,
    output logic                        o_job_en,
    output logic [SAMPLE_BITS-1:0]      o_job_min,
    output logic [SAMPLE_BITS-1:0]      o_job_max
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int EXT_W  = SUM_W - SAMPLE_BITS;
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];

    logic [mavg_pkg::STATE_W-1:0] r_state;
    logic [SAMPLE_BITS-1:0]       r_samp;
    logic [SAMPLE_BITS-1:0]       r_old;
    logic [SUM_W-1:0]             r_sum;
    logic [CNT_W-1:0]             r_cnt;
    logic [SLOT_W-1:0]            r_slot;
    logic [SAMPLE_BITS-1:0]       r_min;
    logic [SAMPLE_BITS-1:0]       r_max;

    logic                   w_take;
    logic                   w_push;
    logic                   w_full;
    logic [SUM_W-1:0]       w_old_ext;
    logic [SUM_W-1:0]       w_new_ext;
    logic [SUM_W-1:0]       n_sum;
    logic [CNT_W-1:0]       n_cnt;
    logic [SAMPLE_BITS-1:0] n_min;
    logic [SAMPLE_BITS-1:0] n_max;

    assign o_ready = (r_state == mavg_pkg::ST_IDLE);
    assign w_take  = i_valid && o_ready;
    assign o_job_valid = (r_state == mavg_pkg::ST_RUN);
    assign w_push  = o_job_valid && i_job_ready;

    assign w_full    = (r_cnt == FULL_CNT);
    assign w_old_ext = {{EXT_W{r_old[SAMPLE_BITS-1]}}, r_old};
    assign w_new_ext = {{EXT_W{r_samp[SAMPLE_BITS-1]}}, r_samp};

    always_comb begin
        // once the ring is full the evicted sample leaves the sum
        n_sum = r_sum - (w_full ? w_old_ext : '0) + w_new_ext;
        n_cnt = w_full ? r_cnt : r_cnt + 1'b1;
        n_min = ($signed(r_samp) < $signed(r_min)) ? r_samp : r_min;
        n_max = ($signed(r_samp) > $signed(r_max)) ? r_samp : r_max;
    end

    assign o_job_sum = n_sum;
    assign o_job_cnt = n_cnt;
    assign o_job_en  = i_avg_en;
    assign o_job_min = n_min;
    assign o_job_max = n_max;

    // ring: old entry read on accept, new entry written on push, same slot
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_old  <= r_ring[r_slot];
            r_samp <= i_sample;
        end
        if (w_push) begin
            r_ring[r_slot] <= r_samp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mavg_pkg::ST_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_slot  <= '0;
            r_min   <= S_MAX;
            r_max   <= S_MIN;
        end else begin
            case (r_state)
                mavg_pkg::ST_IDLE: begin
                    if (w_take) begin
                        r_state <= mavg_pkg::ST_RUN;
                    end
                end
                mavg_pkg::ST_RUN: begin
                    if (i_job_ready) begin
                        r_state <= mavg_pkg::ST_IDLE;
                        r_sum   <= n_sum;
                        r_cnt   <= n_cnt;
                        r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                        r_min   <= n_min;
                        r_max   <= n_max;
                    end
                end
                default: begin
                    r_state <= mavg_pkg::ST_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("fill count beyond window");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_cnt != '0) && (r_state == mavg_pkg::ST_IDLE))
        else $error("push did not advance fill count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> ($signed(r_min) <= $signed(r_max)))
        else $error("running min above running max");

endmodule

`default_nettype wire

// ===== rtl/core/mavg_queue.sv =====
// Two-entry job queue between the front part and the divider.
// Generic data width; no package dependency.
`default_nettype none

module mavg_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mavg_back.sv =====
// Back part: restoring divider (one quotient bit per cycle) and the output register.
// Produces the truncated mean plus the min/max carried with the job.
// Depends on mavg_pkg.
`default_nettype none

module mavg_back #(
    parameter int WINDOW = 100,
    parameter int SAMPLE_BITS = 32,
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW),
    localparam int CNT_W = $clog2(WINDOW + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    output logic                        o_job_ready,
    input  wire logic [SUM_W-1:0]       i_job_sum,
    input  wire logic [CNT_W-1:0]       i_job_cnt,
    input  wire logic                   i_job_en,
    input  wire logic [SAMPLE_BITS-1:0] i_job_min,
    input  wire logic [SAMPLE_BITS-1:0] i_job_max,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_avg,
    output logic                        o_avg_valid,
    output logic [SAMPLE_BITS-1:0]      o_min,
    output logic [SAMPLE_BITS-1:0]      o_max
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic [mavg_pkg::STATE_W-1:0] r_state;
    logic [SUM_W-1:0]             r_quo;
    logic [CNT_W-1:0]             r_rem;
    logic [CNT_W-1:0]             r_den;
    logic [STEP_W-1:0]            r_step;
    logic                         r_neg;
    logic                         r_en;
    logic [SAMPLE_BITS-1:0]       r_jmin;
    logic [SAMPLE_BITS-1:0]       r_jmax;
    logic                         r_ovalid;
    logic [SAMPLE_BITS-1:0]       r_avg;
    logic                         r_aval;
    logic [SAMPLE_BITS-1:0]       r_min;
    logic [SAMPLE_BITS-1:0]       r_max;

    logic             w_pop;
    logic             w_load;
    logic [CNT_W:0]   w_rem_sh;
    logic [CNT_W:0]   w_den_ext;
    logic [CNT_W:0]   w_diff;
    logic             w_ge;
    logic [SUM_W-1:0] w_sgn_quo;

    assign o_job_ready = (r_state == mavg_pkg::ST_IDLE);
    assign w_pop  = i_job_valid && o_job_ready;
    assign w_load = (r_state == mavg_pkg::ST_OUT) && (!r_ovalid || i_ready);

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign w_rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_den_ext = {1'b0, r_den};
    assign w_diff    = w_rem_sh - w_den_ext;
    assign w_ge      = (w_rem_sh >= w_den_ext);
    assign w_sgn_quo = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_neg  <= i_job_sum[SUM_W-1];
            r_quo  <= i_job_sum[SUM_W-1] ? (~i_job_sum + 1'b1) : i_job_sum;
            r_rem  <= '0;
            r_den  <= i_job_cnt;
            r_en   <= i_job_en;
            r_jmin <= i_job_min;
            r_jmax <= i_job_max;
        end else if (r_state == mavg_pkg::ST_RUN) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
        end
        if (w_load) begin
            r_avg  <= r_en ? w_sgn_quo[SAMPLE_BITS-1:0] : '0;
            r_aval <= r_en;
            r_min  <= r_jmin;
            r_max  <= r_jmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mavg_pkg::ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                mavg_pkg::ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= mavg_pkg::ST_RUN;
                        r_step  <= LAST_STEP;
                    end
                end
                mavg_pkg::ST_RUN: begin
                    if (r_step == '0) begin
                        r_state <= mavg_pkg::ST_OUT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                mavg_pkg::ST_OUT: begin
                    if (w_load) begin
                        r_state <= mavg_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= mavg_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_avg       = r_avg;
    assign o_avg_valid = r_aval;
    assign o_min       = r_min;
    assign o_max       = r_max;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mavg_pkg::ST_RUN) |-> (r_den != '0))
        else $error("divide by zero count");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mavg_pkg::ST_RUN) |=> (r_rem < r_den))
        else $error("remainder not reduced");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_valid && (r_state == mavg_pkg::ST_IDLE))
        else $error("result not presented after load");

endmodule

`default_nettype wire

// ===== rtl/core/moving_average_with_min_max_unit.sv =====
// Moving average with running min/max, top level.
//
// Slave stream (i_s_*) takes one signed Q16.16 sample per item in tdata.
// Master stream (o_m_*) gives one result per sample: tdata carries the
// truncated mean of the last WINDOW samples (fewer during warm-up), the
// running minimum and the running maximum; tuser carries the average
// valid flag. With averaging disabled (i_cfg_we / i_cfg_wdata) the mean
// is 0 and the flag low; ring, sum and min/max still update.
// Sums are SUM_W bits wide, where SUM_W = SAMPLE_BITS + clog2(WINDOW)
// (39 at the defaults). The restoring divider retires one quotient
// bit per cycle. The front part takes a new sample only after it has
// pushed the job of the last one (ring read on accept, then sum update
// and ring write on push) and runs ahead of the divider through a
// two-entry job queue.
// A stalled receiver holds the output register; the divider finishes its
// current job and waits, the front keeps working until the queue fills, then o_s_tready drops.
// Reset: averaging enabled, sum and fill count cleared, min at the most
// positive and max at the most negative value. No clearing pass.
`default_nettype none

module moving_average_with_min_max_unit #(
    parameter int WINDOW = 100,
    parameter int SAMPLE_BITS = 32,
    localparam int IN_W  = mavg_pkg::pad_bytes(SAMPLE_BITS),
    localparam int OUT_W = mavg_pkg::pad_bytes(3 * SAMPLE_BITS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,   // sample
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,   // average, running_min, running_max
    output logic                  o_m_tuser,   // average_valid
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_wdata  // averaging_enabled
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int JOB_W = SUM_W + CNT_W + 1 + 2 * SAMPLE_BITS;

    logic r_avg_en;

    logic                   w_fj_valid;
    logic                   w_fj_ready;
    logic [SUM_W-1:0]       w_fj_sum;
    logic [CNT_W-1:0]       w_fj_cnt;
    logic                   w_fj_en;
    logic [SAMPLE_BITS-1:0] w_fj_min;
    logic [SAMPLE_BITS-1:0] w_fj_max;
    logic [JOB_W-1:0]       w_fj_data;

    logic                   w_bj_valid;
    logic                   w_bj_ready;
    logic [JOB_W-1:0]       w_bj_data;

    logic [SAMPLE_BITS-1:0] w_avg;
    logic                   w_avg_valid;
    logic [SAMPLE_BITS-1:0] w_min;
    logic [SAMPLE_BITS-1:0] w_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_avg_en <= i_cfg_wdata;
        end
    end

    mavg_front #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_avg_en    (r_avg_en),
        .o_job_valid (w_fj_valid),
        .i_job_ready (w_fj_ready),
        .o_job_sum   (w_fj_sum),
        .o_job_cnt   (w_fj_cnt),
        .o_job_en    (w_fj_en),
        .o_job_min   (w_fj_min),
        .o_job_max   (w_fj_max)
    );

    assign w_fj_data = {w_fj_max, w_fj_min, w_fj_en, w_fj_cnt, w_fj_sum};

    mavg_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fj_valid),
        .o_ready (w_fj_ready),
        .i_data  (w_fj_data),
        .o_valid (w_bj_valid),
        .i_ready (w_bj_ready),
        .o_data  (w_bj_data)
    );

    mavg_back #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_bj_valid),
        .o_job_ready (w_bj_ready),
        .i_job_sum   (w_bj_data[SUM_W-1:0]),
        .i_job_cnt   (w_bj_data[SUM_W +: CNT_W]),
        .i_job_en    (w_bj_data[SUM_W + CNT_W]),
        .i_job_min   (w_bj_data[SUM_W + CNT_W + 1 +: SAMPLE_BITS]),
        .i_job_max   (w_bj_data[SUM_W + CNT_W + 1 + SAMPLE_BITS +: SAMPLE_BITS]),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_avg       (w_avg),
        .o_avg_valid (w_avg_valid),
        .o_min       (w_min),
        .o_max       (w_max)
    );

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[SAMPLE_BITS-1:0]                 = w_avg;
        o_m_tdata[SAMPLE_BITS +: SAMPLE_BITS]      = w_min;
        o_m_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS]  = w_max;
    end

    assign o_m_tuser = w_avg_valid;

endmodule

`default_nettype wire
